// ----- design/mms_pkg.sv -----
// Shared types and constants for the mean and median sample set unit.
package mms_pkg;

  localparam int SET_SIZE_DEF = 15;
  localparam int SAMPLE_W     = 16;
  localparam int MEAN_W       = 24;
  localparam int MEDIAN_W     = 17;
  localparam int MEAN_SHIFT   = 8;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } st_t;

  // Per-cell insertion control.
  typedef struct packed {
    logic ins;   // sample is being inserted this cycle
    logic occ;   // cell holds an entry of the current set
    logic tail;  // cell is the first free slot
  } cell_ctl_t;

endpackage

// ----- design/mms_cell.sv -----
// One slot of the sorted insertion chain.
module mms_cell (
  input  logic                                  clk,
  input  mms_pkg::cell_ctl_t                    ctl_i,
  input  logic signed [mms_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic signed [mms_pkg::SAMPLE_W-1:0]   left_val_i,
  input  logic                                  left_gt_i,
  output logic signed [mms_pkg::SAMPLE_W-1:0]   val_o,
  output logic                                  gt_o
);

  logic signed [mms_pkg::SAMPLE_W-1:0] val_r;

  assign val_o = val_r;
  assign gt_o  = ctl_i.occ && (val_r > sample_i);

  // Larger entries move one slot right; the gap takes the new sample.
  always_ff @(posedge clk) begin
    if (ctl_i.ins && (gt_o || ctl_i.tail)) begin
      val_r <= left_gt_i ? left_val_i : sample_i;
    end
  end

endmodule

// ----- design/mms_div.sv -----
// Division by a constant through multiplication with a scaled reciprocal.
module mms_div #(
  parameter int DIVISOR = mms_pkg::SET_SIZE_DEF,
  parameter int DW      = 28
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o
);

  // Exact for every dividend below 2**DW: the reciprocal's rounding error
  // times the largest dividend stays under one unit of the quotient.
  localparam int              SHIFT   = DW + $clog2(DIVISOR);
  localparam longint unsigned RECIP   =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int              MW      = $clog2(RECIP + 64'd1);
  localparam int              PW      = SHIFT + DW;
  localparam logic [MW-1:0]   RECIP_M = MW'(RECIP);

  logic          run_r;
  logic          done_r;
  logic [DW-1:0] dd_r;
  logic [DW-1:0] quo_r;
  logic [PW-1:0] prod;

  assign prod   = PW'(dd_r) * PW'(RECIP_M);
  assign done_o = done_r;
  assign quo_o  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= start_i;
      done_r <= run_r;
    end
  end

  // Operand is registered first, the product the cycle after.
  always_ff @(posedge clk) begin
    if (start_i) begin
      dd_r <= dividend_i;
    end
    if (run_r) begin
      quo_r <= prod[PW-1:SHIFT];
    end
  end

endmodule

// ----- design/mean_and_median_of_sample_set_unit.sv -----
// Top level: sorted insertion chain, running sum and mean divider.
//
// One sample is taken per cycle while busy is low (start high, busy low).
// A sample that is zero or odd is flagged as not accepted and leaves the set
// as it was. Each accepted sample drops into a chain of SET_SIZE cells that
// keeps the set in ascending order. For a sample that does not finish the
// set, its result strobes out_valid the next cycle. The sample that finishes
// the set raises busy while the mean is formed: the divider first registers
// the sum magnitude, then multiplies it by a scaled reciprocal of SET_SIZE.
// Its result, with set_done, mean and median, strobes out_valid in the first
// cycle with busy low again. Results cannot be held off, so they must be
// taken in the cycle they appear.
module mean_and_median_of_sample_set_unit #(
  parameter int SET_SIZE = mms_pkg::SET_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [mms_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                  out_valid,
  output logic                                  out_accepted,
  output logic                                  out_set_done,
  output logic signed [mms_pkg::MEAN_W-1:0]     out_mean_scaled,
  output logic signed [mms_pkg::MEDIAN_W-1:0]   out_median_halves
);

  localparam int SW   = mms_pkg::SAMPLE_W;
  localparam int SUMW = SW + $clog2(SET_SIZE);
  localparam int DW   = SUMW + mms_pkg::MEAN_SHIFT;
  localparam int CW   = $clog2(SET_SIZE + 1);
  localparam int MID  = SET_SIZE / 2;
  localparam bit ODD  = (SET_SIZE % 2) != 0;

  mms_pkg::st_t state_r, state_nxt;

  logic                  take;
  logic                  good;
  logic                  ins;
  logic                  last;
  logic [CW-1:0]         count_r;
  logic signed [SUMW-1:0] sum_r;
  logic signed [SUMW-1:0] sum_nxt;
  logic [SUMW-1:0]       sum_mag;
  logic                  neg_r;
  logic                  div_start;
  logic                  div_done;
  logic [DW-1:0]         quo;
  logic [DW-1:0]         quo_signed;
  logic signed [mms_pkg::MEDIAN_W-1:0] median;

  logic signed [SW-1:0] vals [SET_SIZE];
  logic                 gts  [SET_SIZE];

  logic                 valid_r;
  logic                 acc_r;
  logic                 done_r;
  logic signed [mms_pkg::MEAN_W-1:0]   mean_r;
  logic signed [mms_pkg::MEDIAN_W-1:0] med_r;

  assign busy      = (state_r == mms_pkg::ST_DIV);
  assign take      = start && !busy;
  assign good      = (in_sample != '0) && !in_sample[0];
  assign ins       = take && good;
  assign last      = (count_r == CW'(SET_SIZE - 1));
  assign sum_nxt   = sum_r + SUMW'(in_sample);
  assign sum_mag   = sum_nxt[SUMW-1] ? (~sum_nxt + 1'b1) : sum_nxt;
  assign div_start = ins && last;

  // Insertion chain
  for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
    mms_pkg::cell_ctl_t ctl;
    assign ctl = {ins, count_r > CW'(i), count_r == CW'(i)};
    if (i == 0) begin : g_head
      mms_cell u_cell (
        .clk        (clk),
        .ctl_i      (ctl),
        .sample_i   (in_sample),
        .left_val_i (in_sample),
        .left_gt_i  (1'b0),
        .val_o      (vals[i]),
        .gt_o       (gts[i])
      );
    end else begin : g_body
      mms_cell u_cell (
        .clk        (clk),
        .ctl_i      (ctl),
        .sample_i   (in_sample),
        .left_val_i (vals[i-1]),
        .left_gt_i  (gts[i-1]),
        .val_o      (vals[i]),
        .gt_o       (gts[i])
      );
    end
  end

  mms_div #(
    .DIVISOR (SET_SIZE),
    .DW      (DW)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i ({sum_mag, mms_pkg::MEAN_SHIFT'(0)}),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign quo_signed = neg_r ? (~quo + 1'b1) : quo;

  // Cells hold the full sorted set until the next accepted sample.
  if (ODD) begin : g_med_odd
    assign median = {vals[MID], 1'b0};
  end else begin : g_med_even
    assign median = mms_pkg::MEDIAN_W'(vals[MID-1]) + mms_pkg::MEDIAN_W'(vals[MID]);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mms_pkg::ST_IDLE: begin
        if (div_start) begin
          state_nxt = mms_pkg::ST_DIV;
        end
      end
      mms_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = mms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mms_pkg::ST_IDLE;
      count_r <= '0;
      sum_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (take && !div_start) || (busy && div_done);
      if (ins) begin
        if (last) begin
          count_r <= '0;
          sum_r   <= '0;
        end else begin
          count_r <= count_r + 1'b1;
          sum_r   <= sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= sum_nxt[SUMW-1];
    end
    if (busy && div_done) begin
      acc_r  <= 1'b1;
      done_r <= 1'b1;
      mean_r <= quo_signed[mms_pkg::MEAN_W-1:0];
      med_r  <= median;
    end else if (take) begin
      acc_r  <= good;
      done_r <= 1'b0;
      mean_r <= '0;
      med_r  <= '0;
    end
  end

  assign out_valid         = valid_r;
  assign out_accepted      = acc_r;
  assign out_set_done      = done_r;
  assign out_mean_scaled   = mean_r;
  assign out_median_halves = med_r;

endmodule

// ----- design/mms_chk.sv -----
// Port-level checks for the mean and median unit, bound to the top level.
module mms_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic signed [mms_pkg::SAMPLE_W-1:0] in_sample,
  input logic                                out_valid,
  input logic                                out_accepted,
  input logic                                out_set_done,
  input logic signed [mms_pkg::MEAN_W-1:0]   out_mean_scaled,
  input logic signed [mms_pkg::MEDIAN_W-1:0] out_median_halves
);

  // Every transaction yields a result next cycle unless it closed the set.
  a_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("transaction gave neither result nor busy");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_sample == 0 || in_sample[0]) |=> out_valid && !out_accepted)
    else $error("zero or odd sample not rejected");

  a_done_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_set_done |-> out_accepted)
    else $error("set done on a rejected sample");

  a_zero_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_set_done |-> out_mean_scaled == 0 && out_median_halves == 0)
    else $error("statistics present without set done");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_set_done)
    else $error("busy ended without a set result");

endmodule

bind mean_and_median_of_sample_set_unit mms_chk u_mms_chk (.*);
